// ----- rtl/whs_pkg.sv -----
// ----------------------------------------------------------------------------
// whs_pkg
// shared types and constants of the heightfield water block
// ----------------------------------------------------------------------------
package whs_pkg;

   localparam int H_W        = 16;
   localparam int V_W        = 24;
   localparam int SQRT_IN_W  = 36;
   localparam int SQRT_OUT_W = 18;
   localparam int CSR_W      = 15;

   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_RIPPLE = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   localparam logic CSR_DAMPING      = 1'b0;
   localparam logic CSR_HEIGHT_LIMIT = 1'b1;

   localparam logic [8:0]  DAMPING_RST = 9'd243;
   localparam logic [14:0] LIMIT_RST   = 15'd25600;

   typedef enum logic [14:0] {
      S_CLEAR   = 15'b000000000000001,
      S_IDLE    = 15'b000000000000010,
      S_T1_RD   = 15'b000000000000100,
      S_T1_WR   = 15'b000000000001000,
      S_T2_RD   = 15'b000000000010000,
      S_T2_MUL  = 15'b000000000100000,
      S_T2_WR   = 15'b000000001000000,
      S_R_SQX   = 15'b000000010000000,
      S_R_SQY   = 15'b000000100000000,
      S_R_SUM   = 15'b000001000000000,
      S_R_SQRT  = 15'b000010000000000,
      S_R_WR    = 15'b000100000000000,
      S_RD_WAIT = 15'b001000000000000,
      S_RD_DATA = 15'b010000000000000,
      S_FIN     = 15'b100000000000000
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [SQRT_IN_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic                  done;
      logic [SQRT_OUT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

// ----- rtl/whs_sqrt.sv -----
// ----------------------------------------------------------------------------
// whs_sqrt
// iterative integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module whs_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  whs_pkg::sqrt_req_type sq_req,
   output whs_pkg::sqrt_rsp_type sq_rsp
);

   localparam int W = whs_pkg::SQRT_IN_W;

   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] root_ff, root_in;
   logic [W-1:0] bit_ff, bit_in;
   logic         done_ff, done_in;
   logic [W-1:0] trial;

   always_comb begin
      trial   = root_ff + bit_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      done_in = 1'b0;
      if (sq_req.start) begin
         rem_in  = sq_req.radicand;
         root_in = '0;
         bit_in  = W'(1) << (W - 2);
      end else if (bit_ff != '0) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         done_in = (bit_ff == W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         bit_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         bit_ff  <= bit_in;
         done_ff <= done_in;
      end
   end

   assign sq_rsp.done = done_ff;
   assign sq_rsp.root = root_ff[whs_pkg::SQRT_OUT_W-1:0];

endmodule

// ----- rtl/water_heightfield_wave_step.sv -----
// ----------------------------------------------------------------------------
// water_heightfield_wave_step
// heightfield water ripple simulation over a square grid of cells
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// req_*     in         req_valid/req_stall   type, ripple centre/strength, cell
// rsp_*     out        rsp_valid/rsp_stall   height, velocity, saturation flag
// csr_*     in         csr_we                index, write data
//
// tick: a height pass (read, write per interior cell), then a velocity pass
// (reads, multiply, write), set by the single read port of the height memory.
// ripple: each window cell is paced by the 18-step square root; a cell that
// gains velocity also takes a write state.
// read: one item at a time; req_stall is high while an item runs.
// after reset both grids are swept to zero, one entry per cycle
// (GRID_SIZE rounded up to a power of two, squared: 4096 entries at 64).
// the result register holds while rsp_stall is high; the block waits on it.
// ----------------------------------------------------------------------------
module water_heightfield_wave_step #(
   parameter int GRID_SIZE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [11:0] req_ripple_row,
   input  logic [11:0] req_ripple_col,
   input  logic [7:0]  req_ripple_strength,
   input  logic [5:0]  req_cell_row,
   input  logic [5:0]  req_cell_col,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_height_value,
   output logic signed [23:0] rsp_velocity_value,
   output logic        rsp_velocity_saturated,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [14:0] csr_wdata
);

   localparam int RW     = $clog2(GRID_SIZE);
   localparam int ADDR_W = 2 * RW;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int WIN_W  = 9;
   localparam logic [RW-1:0]    LAST_IN = RW'(GRID_SIZE - 2);
   localparam logic [WIN_W-1:0] EDGE_HI = WIN_W'(GRID_SIZE - 1);
   localparam logic [12:0]      WIN_LIM = 13'((GRID_SIZE - 5) * 16);
   localparam logic [8:0]       GRID_N  = 9'(GRID_SIZE);
   localparam logic signed [40:0] VMAX41 = 41'sd8388607;
   localparam logic signed [40:0] VMIN41 = -41'sd8388608;
   localparam logic signed [24:0] VMAX25 = 25'sd8388607;

   whs_pkg::state_type state_ff, state_in;

   // grids
   logic signed [15:0] h_mem [DEPTH];
   logic signed [23:0] v_mem [DEPTH];
   logic signed [15:0] h_rd_ff;
   logic signed [23:0] v_rd_ff;
   logic [ADDR_W-1:0]  raddr;
   logic               h_we, v_we;
   logic [ADDR_W-1:0]  h_waddr, v_waddr;
   logic signed [15:0] h_wdata;
   logic signed [23:0] v_wdata;

   logic [8:0]  damp_ff;
   logic [14:0] lim_ff;

   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [2:0]        stp_ff, stp_in;
   logic [RW-1:0]     row_ff, row_in, col_ff, col_in;
   logic [1:0]        kind_ff, kind_in;
   logic [11:0]       rrow_ff, rrow_in, rcol_ff, rcol_in;
   logic [7:0]        rstr_ff, rstr_in;
   logic [5:0]        crow_ff, crow_in, ccol_ff, ccol_in;
   logic [WIN_W-1:0]  ri_ff, ri_in, rj_ff, rj_in;
   logic [WIN_W-1:0]  jlo_ff, jlo_in, ihi_ff, ihi_in, jhi_ff, jhi_in;
   logic signed [19:0] lap_ff, lap_in;
   logic signed [23:0] v_ff, v_in;
   logic [27:0]        d2_ff, d2_in;
   logic signed [40:0] prod_ff;
   logic               sat_ff, sat_in;
   logic signed [15:0] res_h_ff, res_h_in;
   logic signed [23:0] res_v_ff, res_v_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_h_ff, rsp_h_in;
   logic signed [23:0] rsp_v_ff, rsp_v_in;
   logic               rsp_sat_ff, rsp_sat_in;

   logic signed [26:0] mul_a;
   logic signed [13:0] mul_b;
   logic signed [40:0] mul_p;

   whs_pkg::sqrt_req_type sq_req;
   whs_pkg::sqrt_rsp_type sq_rsp;

   logic               req_acc;
   logic [WIN_W-1:0]   ilo_c, ihi_c, jlo_c, jhi_c;
   logic [11:0]        row_m48, col_m48;
   logic [12:0]        row_p64, col_p64;
   logic signed [13:0] dx, dy;
   logic signed [25:0] tval;
   logic signed [40:0] qv;
   logic signed [24:0] hsum, lim25, rsum;
   logic [9:0]         accv;
   logic               cell_in_range;
   logic               tick_last;
   logic               rip_last;

   whs_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .sq_req (sq_req),
      .sq_rsp (sq_rsp)
   );

   assign req_stall = (state_ff != whs_pkg::S_IDLE);
   assign req_acc   = req_valid && !req_stall;

   // ripple window bounds from the fixed-point centre
   always_comb begin
      row_m48 = req_ripple_row - 12'd48;
      col_m48 = req_ripple_col - 12'd48;
      row_p64 = {1'b0, req_ripple_row} + 13'd64;
      col_p64 = {1'b0, req_ripple_col} + 13'd64;
      ilo_c = (req_ripple_row > 12'd80) ? {1'b0, row_m48[11:4]} : WIN_W'(2);
      jlo_c = (req_ripple_col > 12'd80) ? {1'b0, col_m48[11:4]} : WIN_W'(2);
      ihi_c = ({1'b0, req_ripple_row} < WIN_LIM) ? row_p64[12:4] : EDGE_HI;
      jhi_c = ({1'b0, req_ripple_col} < WIN_LIM) ? col_p64[12:4] : EDGE_HI;
   end

   always_comb begin
      dx   = $signed({2'b00, rrow_ff}) - $signed({1'b0, ri_ff, 4'b0000});
      dy   = $signed({2'b00, rcol_ff}) - $signed({1'b0, rj_ff, 4'b0000});
      tval = $signed({v_ff, 1'b0}) + 26'(lap_ff);
      qv   = (prod_ff + 41'sd256) >>> 9;
      hsum = 25'(h_rd_ff) + 25'(v_rd_ff);
      lim25 = $signed({10'b0, lim_ff});
      rsum = 25'(v_ff) + $signed({7'b0, prod_ff[17:0]});
      accv = 10'd768 - sq_rsp.root[9:0];
      cell_in_range = ({3'b000, crow_ff} < GRID_N) && ({3'b000, ccol_ff} < GRID_N);
      tick_last = (row_ff == LAST_IN) && (col_ff == LAST_IN);
      rip_last  = (rj_ff + WIN_W'(1) >= jhi_ff) && (ri_ff + WIN_W'(1) >= ihi_ff);
   end

   // the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         whs_pkg::S_T2_MUL: begin
            mul_a = 27'(tval);
            mul_b = $signed({5'b0, damp_ff});
         end
         whs_pkg::S_R_SQX: begin
            mul_a = 27'(dx);
            mul_b = dx;
         end
         whs_pkg::S_R_SQY: begin
            mul_a = 27'(dy);
            mul_b = dy;
         end
         whs_pkg::S_R_SQRT: begin
            mul_a = $signed({17'b0, accv});
            mul_b = $signed({6'b0, rstr_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      stp_in   = stp_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      kind_in  = kind_ff;
      rrow_in  = rrow_ff;
      rcol_in  = rcol_ff;
      rstr_in  = rstr_ff;
      crow_in  = crow_ff;
      ccol_in  = ccol_ff;
      ri_in    = ri_ff;
      rj_in    = rj_ff;
      jlo_in   = jlo_ff;
      ihi_in   = ihi_ff;
      jhi_in   = jhi_ff;
      lap_in   = lap_ff;
      v_in     = v_ff;
      d2_in    = d2_ff;
      sat_in   = sat_ff;
      res_h_in = res_h_ff;
      res_v_in = res_v_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_h_in   = rsp_h_ff;
      rsp_v_in   = rsp_v_ff;
      rsp_sat_in = rsp_sat_ff;
      raddr    = {ri_ff[RW-1:0], rj_ff[RW-1:0]};
      h_we     = 1'b0;
      v_we     = 1'b0;
      h_waddr  = {row_ff, col_ff};
      v_waddr  = {row_ff, col_ff};
      h_wdata  = '0;
      v_wdata  = '0;
      sq_req.start    = 1'b0;
      sq_req.radicand = {d2_ff + prod_ff[27:0], 8'b0};

      case (state_ff)
         whs_pkg::S_CLEAR: begin
            h_we    = 1'b1;
            v_we    = 1'b1;
            h_waddr = clr_ff;
            v_waddr = clr_ff;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) state_in = whs_pkg::S_IDLE;
         end
         whs_pkg::S_IDLE: begin
            if (req_acc) begin
               kind_in  = req_type;
               rrow_in  = req_ripple_row;
               rcol_in  = req_ripple_col;
               rstr_in  = req_ripple_strength;
               crow_in  = req_cell_row;
               ccol_in  = req_cell_col;
               sat_in   = 1'b0;
               res_h_in = '0;
               res_v_in = '0;
               row_in   = RW'(1);
               col_in   = RW'(1);
               stp_in   = '0;
               ri_in    = ilo_c;
               rj_in    = jlo_c;
               jlo_in   = jlo_c;
               ihi_in   = ihi_c;
               jhi_in   = jhi_c;
               case (req_type)
                  whs_pkg::REQ_TICK:   state_in = whs_pkg::S_T1_RD;
                  whs_pkg::REQ_RIPPLE: begin
                     if (ilo_c < ihi_c && jlo_c < jhi_c) state_in = whs_pkg::S_R_SQX;
                     else state_in = whs_pkg::S_FIN;
                  end
                  whs_pkg::REQ_READ:   state_in = whs_pkg::S_RD_WAIT;
                  default:             state_in = whs_pkg::S_FIN;
               endcase
            end
         end
         whs_pkg::S_T1_RD: begin
            raddr    = {row_ff, col_ff};
            state_in = whs_pkg::S_T1_WR;
         end
         whs_pkg::S_T1_WR: begin
            h_we = 1'b1;
            if (hsum > lim25) h_wdata = 16'(lim25);
            else if (hsum < -lim25) h_wdata = 16'(-lim25);
            else h_wdata = 16'(hsum);
            state_in = whs_pkg::S_T1_RD;
            if (col_ff == LAST_IN) begin
               col_in = RW'(1);
               row_in = row_ff + RW'(1);
            end else begin
               col_in = col_ff + RW'(1);
            end
            if (tick_last) begin
               row_in   = RW'(1);
               col_in   = RW'(1);
               stp_in   = '0;
               state_in = whs_pkg::S_T2_RD;
            end
         end
         whs_pkg::S_T2_RD: begin
            // centre, west, east, north, south; the read data is registered behind the address
            case (stp_ff)
               3'd0: raddr = {row_ff, col_ff};
               3'd1: raddr = {row_ff, col_ff - RW'(1)};
               3'd2: raddr = {row_ff, col_ff + RW'(1)};
               3'd3: raddr = {row_ff - RW'(1), col_ff};
               default: raddr = {row_ff + RW'(1), col_ff};
            endcase
            if (stp_ff == 3'd1) begin
               lap_in = -($signed(20'(h_rd_ff)) <<< 2);
               v_in   = v_rd_ff;
            end else if (stp_ff != 3'd0) begin
               lap_in = lap_ff + 20'(h_rd_ff);
            end
            stp_in = stp_ff + 3'd1;
            if (stp_ff == 3'd5) state_in = whs_pkg::S_T2_MUL;
         end
         whs_pkg::S_T2_MUL: begin
            state_in = whs_pkg::S_T2_WR;
         end
         whs_pkg::S_T2_WR: begin
            v_we = 1'b1;
            if (qv > VMAX41) begin
               v_wdata = 24'sh7FFFFF;
               sat_in  = 1'b1;
            end else if (qv < VMIN41) begin
               v_wdata = 24'sh800000;
               sat_in  = 1'b1;
            end else begin
               v_wdata = 24'(qv);
            end
            stp_in   = '0;
            state_in = whs_pkg::S_T2_RD;
            if (col_ff == LAST_IN) begin
               col_in = RW'(1);
               row_in = row_ff + RW'(1);
            end else begin
               col_in = col_ff + RW'(1);
            end
            if (tick_last) state_in = whs_pkg::S_FIN;
         end
         whs_pkg::S_R_SQX: begin
            state_in = whs_pkg::S_R_SQY;
         end
         whs_pkg::S_R_SQY: begin
            d2_in    = prod_ff[27:0];
            v_in     = v_rd_ff;
            state_in = whs_pkg::S_R_SUM;
         end
         whs_pkg::S_R_SUM: begin
            sq_req.start = 1'b1;
            state_in     = whs_pkg::S_R_SQRT;
         end
         whs_pkg::S_R_SQRT: begin
            if (sq_rsp.done) begin
               if (sq_rsp.root < 18'd768) begin
                  state_in = whs_pkg::S_R_WR;
               end else begin
                  // no gain at this distance: next cell
                  state_in = rip_last ? whs_pkg::S_FIN : whs_pkg::S_R_SQX;
                  if (rj_ff + WIN_W'(1) >= jhi_ff) begin
                     rj_in = jlo_ff;
                     ri_in = ri_ff + WIN_W'(1);
                  end else begin
                     rj_in = rj_ff + WIN_W'(1);
                  end
               end
            end
         end
         whs_pkg::S_R_WR: begin
            v_we    = 1'b1;
            v_waddr = {ri_ff[RW-1:0], rj_ff[RW-1:0]};
            if (rsum > VMAX25) begin
               v_wdata = 24'sh7FFFFF;
               sat_in  = 1'b1;
            end else begin
               v_wdata = 24'(rsum);
            end
            state_in = rip_last ? whs_pkg::S_FIN : whs_pkg::S_R_SQX;
            if (rj_ff + WIN_W'(1) >= jhi_ff) begin
               rj_in = jlo_ff;
               ri_in = ri_ff + WIN_W'(1);
            end else begin
               rj_in = rj_ff + WIN_W'(1);
            end
         end
         whs_pkg::S_RD_WAIT: begin
            raddr    = {RW'(crow_ff), RW'(ccol_ff)};
            state_in = whs_pkg::S_RD_DATA;
         end
         whs_pkg::S_RD_DATA: begin
            if (cell_in_range) begin
               res_h_in = h_rd_ff;
               res_v_in = v_rd_ff;
            end
            state_in = whs_pkg::S_FIN;
         end
         whs_pkg::S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_h_in     = res_h_ff;
               rsp_v_in     = res_v_ff;
               rsp_sat_in   = sat_ff && (kind_ff == whs_pkg::REQ_TICK ||
                                         kind_ff == whs_pkg::REQ_RIPPLE);
               state_in     = whs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = whs_pkg::S_IDLE;
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (h_we) h_mem[h_waddr] <= h_wdata;
      if (v_we) v_mem[v_waddr] <= v_wdata;
      h_rd_ff <= h_mem[raddr];
      v_rd_ff <= v_mem[raddr];
   end

   always_ff @(posedge clock) begin
      stp_ff   <= stp_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      kind_ff  <= kind_in;
      rrow_ff  <= rrow_in;
      rcol_ff  <= rcol_in;
      rstr_ff  <= rstr_in;
      crow_ff  <= crow_in;
      ccol_ff  <= ccol_in;
      ri_ff    <= ri_in;
      rj_ff    <= rj_in;
      jlo_ff   <= jlo_in;
      ihi_ff   <= ihi_in;
      jhi_ff   <= jhi_in;
      lap_ff   <= lap_in;
      v_ff     <= v_in;
      d2_ff    <= d2_in;
      prod_ff  <= mul_p;
      sat_ff   <= sat_in;
      res_h_ff <= res_h_in;
      res_v_ff <= res_v_in;
      rsp_h_ff   <= rsp_h_in;
      rsp_v_ff   <= rsp_v_in;
      rsp_sat_ff <= rsp_sat_in;
      if (reset) begin
         state_ff     <= whs_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         damp_ff      <= whs_pkg::DAMPING_RST;
         lim_ff       <= whs_pkg::LIMIT_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_addr == whs_pkg::CSR_DAMPING) damp_ff <= csr_wdata[8:0];
         if (csr_we && csr_addr == whs_pkg::CSR_HEIGHT_LIMIT) lim_ff <= csr_wdata;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_height_value       = rsp_h_ff;
   assign rsp_velocity_value     = rsp_v_ff;
   assign rsp_velocity_saturated = rsp_sat_ff;

   // a result appears only from the finishing state
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == whs_pkg::S_FIN))
      else $error("result raised outside the finishing state");

   // border cells are left alone once the grids are cleared
   a_border_kept: assert property (@(posedge clock) disable iff (reset)
      (v_we && state_ff != whs_pkg::S_CLEAR) |->
         (v_waddr[ADDR_W-1:RW] != '0 && v_waddr[RW-1:0] != '0 &&
          v_waddr[ADDR_W-1:RW] != EDGE_HI[RW-1:0] &&
          v_waddr[RW-1:0] != EDGE_HI[RW-1:0]))
      else $error("velocity write to a border cell");

   a_sqrt_done_waited: assert property (@(posedge clock) disable iff (reset)
      sq_rsp.done |-> state_ff == whs_pkg::S_R_SQRT)
      else $error("square root finished with nobody waiting");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == whs_pkg::S_IDLE |-> !h_we && !v_we)
      else $error("grid written while idle");

endmodule
